// ===== rtl/hvac_mode_controller_assert.svh =====
// Assertion macros used by the hvac mode controller checker.
`ifndef HVAC_MODE_CONTROLLER_ASSERT_SVH
`define HVAC_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hvac_mode_controller: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hvac_mode_controller: check failed");

`endif

// ===== rtl/hmc_pkg.sv =====
// Types, constants and register map of the hvac mode controller.
package hmc_pkg;

  // Field widths
  localparam int unsigned TIMER_WIDTH    = 16;
  localparam int unsigned TEMP_WIDTH     = 12;
  localparam int unsigned HYST_WIDTH     = 8;
  localparam int unsigned SEC_WIDTH      = 16;
  localparam int unsigned CFG_DATA_WIDTH = 16;
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned MODE_WIDTH     = 2;

  // Widths for the compares: temperature against setpoint +/- margin,
  // timer against the minimum times
  localparam int unsigned CMP_WIDTH  = TEMP_WIDTH + 2;
  localparam int unsigned TCMP_WIDTH = (TIMER_WIDTH > SEC_WIDTH) ? TIMER_WIDTH : SEC_WIDTH;

  typedef logic signed [TEMP_WIDTH-1:0]  temp_t;
  typedef logic signed [CMP_WIDTH-1:0]   cmp_t;
  typedef logic        [TIMER_WIDTH-1:0] timer_t;
  typedef logic        [TCMP_WIDTH-1:0]  tcmp_t;
  typedef logic        [HYST_WIDTH-1:0]  hyst_t;
  typedef logic        [SEC_WIDTH-1:0]   sec_t;
  typedef logic        [MODE_WIDTH-1:0]  mode_code_t;
  typedef logic        [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_COOL_SETPOINT = 3'd0;
  localparam cfg_idx_t REG_HEAT_SETPOINT = 3'd1;
  localparam cfg_idx_t REG_HYSTERESIS    = 3'd2;
  localparam cfg_idx_t REG_MIN_COOL_ON   = 3'd3;
  localparam cfg_idx_t REG_MIN_HEAT_ON   = 3'd4;
  localparam cfg_idx_t REG_MIN_COOL_OFF  = 3'd5;
  localparam cfg_idx_t REG_MIN_HEAT_OFF  = 3'd6;

  // Register reset values
  localparam temp_t COOL_SETPOINT_RST = temp_t'(250);
  localparam temp_t HEAT_SETPOINT_RST = temp_t'(200);
  localparam hyst_t HYSTERESIS_RST    = hyst_t'(5);
  localparam sec_t  MIN_SECONDS_RST   = sec_t'(300);

  // Mode codes as shown on the result channel
  localparam mode_code_t MODE_OFF  = 2'd0;
  localparam mode_code_t MODE_COOL = 2'd1;
  localparam mode_code_t MODE_HEAT = 2'd2;

  // Controller state, one-hot
  typedef enum logic [2:0] {
    ST_OFF  = 3'b001,
    ST_COOL = 3'b010,
    ST_HEAT = 3'b100
  } mode_state_e;

  // Configuration register set
  typedef struct packed {
    temp_t cool_setpoint;
    temp_t heat_setpoint;
    hyst_t hysteresis;
    sec_t  min_cool_on;
    sec_t  min_heat_on;
    sec_t  min_cool_off;
    sec_t  min_heat_off;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic       cooling_on;
    logic       heating_on;
    mode_code_t mode;
    logic       switched;
  } result_t;

endpackage

// ===== rtl/hvac_mode_controller.sv =====
// Top level of the hvac mode controller: input register, mode logic, result register.
//
// Use: each input beat (temperature_i, second_tick_i) yields exactly one result
// beat (cooling_on_o, heating_on_o, mode_o, switched_o), in order.
// Input channel in_valid_i/in_ready_o, result channel out_valid_o/out_ready_i.
// Configuration: write cfg_data_i to register cfg_index_i with cfg_valid_i;
// cfg_ready_o is always high; indexes beyond six are dropped. Write only while
// no item is in flight.
// Path: an accepted beat is held in the input register, then loaded into the
// result register, from which it is shown on the result channel.
// Throughput: one item per cycle while out_ready_i stays high; the input register
// feeds the mode logic and result register in one step, and the mode/timer
// registers update as the item moves into the result register.
// Stall: while the receiver holds out_ready_i low the result holds; one more
// item may wait in the input register, then in_ready_o drops.
// Reset: both drives off, mode off, timer zero, registers at their defaults,
// both pipeline slots empty.
module hvac_mode_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [hmc_pkg::TEMP_WIDTH-1:0] temperature_i,
  input  logic                               second_tick_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               cooling_on_o,
  output logic                               heating_on_o,
  output logic [hmc_pkg::MODE_WIDTH-1:0]     mode_o,
  output logic                               switched_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hmc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [hmc_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);

  hmc_pkg::cfg_t    cfg;
  hmc_pkg::result_t result;
  hmc_pkg::result_t res_q;
  hmc_pkg::temp_t   temp_q;
  logic             tick_q;
  logic             in_vld_q, out_vld_q;
  logic             step;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  hmc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Advance the held item when the result register is free or being drained
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      temp_q <= temperature_i;
      tick_q <= second_tick_i;
    end
  end

  hmc_mode_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .temperature_i (temp_q),
    .second_tick_i (tick_q),
    .cfg_i         (cfg),
    .result_o      (result)
  );

  // Result register: load on step, drop the valid when drained with nothing behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Hold both drives off until the first result beat is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q.cooling_on <= 1'b0;
      res_q.heating_on <= 1'b0;
      res_q.mode       <= hmc_pkg::MODE_OFF;
      res_q.switched   <= 1'b0;
    end else if (step) begin
      res_q <= result;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cooling_on_o = res_q.cooling_on;
  assign heating_on_o = res_q.heating_on;
  assign mode_o       = res_q.mode;
  assign switched_o   = res_q.switched;

endmodule

// ===== rtl/hmc_cfg_regs.sv =====
// Configuration register file of the hvac mode controller.
module hmc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  hmc_pkg::cfg_idx_t wr_idx_i,
  input  logic [hmc_pkg::CFG_DATA_WIDTH-1:0] wr_data_i,
  output hmc_pkg::cfg_t     cfg_o
);

  hmc_pkg::cfg_t cfg_d, cfg_q;

  // Decode the write beat into the addressed register; drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        hmc_pkg::REG_COOL_SETPOINT:
          cfg_d.cool_setpoint = hmc_pkg::temp_t'(wr_data_i[hmc_pkg::TEMP_WIDTH-1:0]);
        hmc_pkg::REG_HEAT_SETPOINT:
          cfg_d.heat_setpoint = hmc_pkg::temp_t'(wr_data_i[hmc_pkg::TEMP_WIDTH-1:0]);
        hmc_pkg::REG_HYSTERESIS:
          cfg_d.hysteresis = wr_data_i[hmc_pkg::HYST_WIDTH-1:0];
        hmc_pkg::REG_MIN_COOL_ON:  cfg_d.min_cool_on  = wr_data_i[hmc_pkg::SEC_WIDTH-1:0];
        hmc_pkg::REG_MIN_HEAT_ON:  cfg_d.min_heat_on  = wr_data_i[hmc_pkg::SEC_WIDTH-1:0];
        hmc_pkg::REG_MIN_COOL_OFF: cfg_d.min_cool_off = wr_data_i[hmc_pkg::SEC_WIDTH-1:0];
        hmc_pkg::REG_MIN_HEAT_OFF: cfg_d.min_heat_off = wr_data_i[hmc_pkg::SEC_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cool_setpoint <= hmc_pkg::COOL_SETPOINT_RST;
      cfg_q.heat_setpoint <= hmc_pkg::HEAT_SETPOINT_RST;
      cfg_q.hysteresis    <= hmc_pkg::HYSTERESIS_RST;
      cfg_q.min_cool_on   <= hmc_pkg::MIN_SECONDS_RST;
      cfg_q.min_heat_on   <= hmc_pkg::MIN_SECONDS_RST;
      cfg_q.min_cool_off  <= hmc_pkg::MIN_SECONDS_RST;
      cfg_q.min_heat_off  <= hmc_pkg::MIN_SECONDS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hmc_mode_fsm.sv =====
// Mode state machine and seconds-in-mode timer of the hvac mode controller.
module hmc_mode_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  hmc_pkg::temp_t   temperature_i,
  input  logic             second_tick_i,
  input  hmc_pkg::cfg_t    cfg_i,
  output hmc_pkg::result_t result_o
);

  hmc_pkg::mode_state_e mode_d, mode_q;
  hmc_pkg::timer_t      timer_d, timer_q;
  hmc_pkg::timer_t      timer_inc;
  hmc_pkg::tcmp_t       timer_ext;
  hmc_pkg::cmp_t        temp_x, cool_x, heat_x, hyst_x;
  logic                 cool_stop, heat_stop, cool_start, heat_start;
  logic                 sw;

  // Advance the timer on a tick, saturating at its maximum
  always_comb begin
    timer_inc = timer_q;
    if (second_tick_i && (timer_q != '1)) begin
      timer_inc = timer_q + hmc_pkg::timer_t'(1);
    end
  end

  // Widen the operands for exact compares
  assign timer_ext = hmc_pkg::tcmp_t'(timer_inc);
  assign temp_x    = hmc_pkg::cmp_t'(temperature_i);
  assign cool_x    = hmc_pkg::cmp_t'(cfg_i.cool_setpoint);
  assign heat_x    = hmc_pkg::cmp_t'(cfg_i.heat_setpoint);
  assign hyst_x    = hmc_pkg::cmp_t'($signed({1'b0, cfg_i.hysteresis}));

  assign cool_stop  = (timer_ext >= hmc_pkg::tcmp_t'(cfg_i.min_cool_on)) &&
                      (temp_x < (cool_x - hyst_x));
  assign heat_stop  = (timer_ext >= hmc_pkg::tcmp_t'(cfg_i.min_heat_on)) &&
                      (temp_x > (heat_x + hyst_x));
  assign cool_start = (temp_x > cool_x) &&
                      (timer_ext >= hmc_pkg::tcmp_t'(cfg_i.min_cool_off));
  assign heat_start = (temp_x < heat_x) &&
                      (timer_ext >= hmc_pkg::tcmp_t'(cfg_i.min_heat_off));

  // Pick the next mode; cooling wins over heating from off
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      hmc_pkg::ST_COOL: if (cool_stop) mode_d = hmc_pkg::ST_OFF;
      hmc_pkg::ST_HEAT: if (heat_stop) mode_d = hmc_pkg::ST_OFF;
      hmc_pkg::ST_OFF: begin
        if (cool_start) begin
          mode_d = hmc_pkg::ST_COOL;
        end else if (heat_start) begin
          mode_d = hmc_pkg::ST_HEAT;
        end
      end
      default: mode_d = hmc_pkg::ST_OFF;
    endcase
  end

  // Clear the timer on every transition
  assign sw      = (mode_d != mode_q);
  assign timer_d = sw ? '0 : timer_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= hmc_pkg::ST_OFF;
      timer_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      timer_q <= timer_d;
    end
  end

  // Build the result beat from the mode after this item
  always_comb begin
    result_o.cooling_on = (mode_d == hmc_pkg::ST_COOL);
    result_o.heating_on = (mode_d == hmc_pkg::ST_HEAT);
    result_o.switched   = sw;
    unique case (mode_d)
      hmc_pkg::ST_COOL: result_o.mode = hmc_pkg::MODE_COOL;
      hmc_pkg::ST_HEAT: result_o.mode = hmc_pkg::MODE_HEAT;
      default:          result_o.mode = hmc_pkg::MODE_OFF;
    endcase
  end

endmodule

// ===== rtl/hmc_checker.sv =====
// Port-level checker of the hvac mode controller, bound to the top level.
`include "hvac_mode_controller_assert.svh"

module hmc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           cooling_on_o,
  input logic                           heating_on_o,
  input logic [hmc_pkg::MODE_WIDTH-1:0] mode_o,
  input logic                           switched_o
);

  logic out_fire;
  logic out_stall;
  logic drive_ok;

  assign out_fire  = out_valid_o && out_ready_i;
  assign out_stall = out_valid_o && !out_ready_i;
  assign drive_ok  = (cooling_on_o == (mode_o == hmc_pkg::MODE_COOL)) &&
                     (heating_on_o == (mode_o == hmc_pkg::MODE_HEAT));

  // Two result beats back to back, the second without a switch
  sequence s_kept_fire;
    out_fire ##1 (out_fire && !switched_o);
  endsequence

  // Two result beats back to back, the second leaving cooling or heating
  sequence s_stop_fire;
    out_fire ##1 (out_fire && switched_o && ($past(mode_o) != hmc_pkg::MODE_OFF));
  endsequence

  // A stalled result beat holds
  `HMC_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(mode_o) && $stable(switched_o))

  // Drive outputs agree with the reported mode
  `HMC_ASSERT_IMP(a_drive_mode, out_valid_o, drive_ok)

  // Without a switch, back-to-back results keep the mode
  `HMC_ASSERT_IMP(a_mode_kept, s_kept_fire, mode_o == $past(mode_o))

  // Leaving cooling or heating always goes to off
  `HMC_ASSERT_IMP(a_stop_to_off, s_stop_fire, mode_o == hmc_pkg::MODE_OFF)

endmodule

bind hvac_mode_controller hmc_checker u_hmc_checker (.*);
